FILE: src/olde_pkg.sv
package olde_pkg;

  localparam int CAP     = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(CAP + 1);
  localparam int IDX_W   = $clog2(CAP);
  localparam int OPC_W   = 3;
  localparam int ST_W    = 2;
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_ORDERED    = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DELETE     = 3'd4,
    OP_READ_FRONT = 3'd5,
    OP_READ_BACK  = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_APPLY = 1'b1
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic              is_insert;
    logic              needs_elem;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

FILE: src/olde_if.sv
interface olde_req_if;
  logic                         valid;
  logic                         ready;
  logic [olde_pkg::OPC_W-1:0]   opcode;
  logic [olde_pkg::DATA_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface olde_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [olde_pkg::DATA_W-1:0]  data;
  logic [olde_pkg::ST_W-1:0]    status;
  logic [olde_pkg::CNT_W-1:0]   count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

FILE: src/olde_front.sv
module olde_front (
  olde_req_if.sink        req,
  input  logic            q_full,
  output logic            wr_en,
  output olde_pkg::cmd_t  wr_cmd
);

  olde_pkg::op_t op;

  assign req.ready = !q_full;
  assign wr_en     = req.valid && !q_full;
  assign op        = olde_pkg::op_t'(req.opcode);

  always_comb begin
    wr_cmd.op         = op;
    wr_cmd.value      = req.value;
    wr_cmd.is_insert  = 1'b0;
    wr_cmd.needs_elem = 1'b0;
    case (op)
      olde_pkg::OP_PUSH_FRONT,
      olde_pkg::OP_PUSH_BACK,
      olde_pkg::OP_ORDERED: begin
        wr_cmd.is_insert = 1'b1;
      end
      olde_pkg::OP_POP_FRONT,
      olde_pkg::OP_DELETE,
      olde_pkg::OP_READ_FRONT,
      olde_pkg::OP_READ_BACK: begin
        wr_cmd.needs_elem = 1'b1;
      end
      default: begin
        wr_cmd.is_insert  = 1'b0;
        wr_cmd.needs_elem = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/olde_cmd_queue.sv
module olde_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  olde_pkg::cmd_t  wr_cmd,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output olde_pkg::cmd_t  rd_cmd
);

  olde_pkg::cmd_t                 entries [olde_pkg::Q_DEPTH];
  logic [olde_pkg::QPTR_W-1:0]    wr_ptr;
  logic [olde_pkg::QPTR_W-1:0]    rd_ptr;
  logic [olde_pkg::QCNT_W-1:0]    fill;

  assign full     = (fill == olde_pkg::QCNT_W'(olde_pkg::Q_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == olde_pkg::QPTR_W'(olde_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == olde_pkg::QPTR_W'(olde_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

FILE: src/olde_back.sv
module olde_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  olde_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  olde_rsp_if.source      rsp
);

  localparam int CAP    = olde_pkg::CAP;
  localparam int DATA_W = olde_pkg::DATA_W;
  localparam int CNT_W  = olde_pkg::CNT_W;
  localparam int IDX_W  = olde_pkg::IDX_W;

  // Each entry is a cell with its own comparator; the list runs front to back.
  logic [DATA_W-1:0]     store      [CAP];
  logic [DATA_W-1:0]     store_next [CAP];
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  olde_pkg::bk_state_t   state;
  olde_pkg::bk_state_t   state_next;
  olde_pkg::cmd_t        cmd;
  logic [CAP-1:0]        hit;
  logic [CAP-1:0]        hit_next;

  logic                  out_valid;
  logic [DATA_W-1:0]     out_data;
  olde_pkg::status_t     out_status;
  logic [CNT_W-1:0]      out_count;

  logic                  apply_done;
  logic                  do_write;
  logic [DATA_W-1:0]     data_next;
  olde_pkg::status_t     status_next;
  logic [CAP-1:0]        first;
  logic [CAP-1:0]        tail_oh;
  logic [CAP-1:0]        at;
  logic [CAP-1:0]        below;
  logic [IDX_W-1:0]      last;
  logic [CNT_W-1:0]      last_full;

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;
  assign rsp.count  = out_count;

  // Cell compares against the word at the head of the queue.
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      if (CNT_W'(i) < count) begin
        if (q_cmd.op == olde_pkg::OP_ORDERED) begin
          hit_next[i] = !(store[i] < q_cmd.value);
        end else begin
          hit_next[i] = (store[i] == q_cmd.value);
        end
      end else begin
        hit_next[i] = 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      olde_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = olde_pkg::BK_APPLY;
        end
      end
      olde_pkg::BK_APPLY: begin
        if (!out_valid || rsp.ready) begin
          state_next = olde_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = olde_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop      = 1'b0;
    apply_done = 1'b0;
    case (state)
      olde_pkg::BK_IDLE: begin
        q_pop = q_valid;
      end
      olde_pkg::BK_APPLY: begin
        apply_done = !out_valid || rsp.ready;
      end
      default: begin
        q_pop      = 1'b0;
        apply_done = 1'b0;
      end
    endcase
  end

  // Position masks: at marks the slot that is filled or vacated, below the
  // slots in front of it that stay put.
  always_comb begin
    first     = hit & (~hit + CAP'(1));
    tail_oh   = CAP'(1) << count;
    last_full = count - 1'b1;
    last      = last_full[IDX_W-1:0];
    case (cmd.op)
      olde_pkg::OP_PUSH_BACK: at = tail_oh;
      olde_pkg::OP_ORDERED:   at = (hit != '0) ? first : tail_oh;
      olde_pkg::OP_DELETE:    at = first;
      default:                at = CAP'(1);
    endcase
    below = at - CAP'(1);
  end

  always_comb begin
    status_next = olde_pkg::ST_OK;
    data_next   = '0;
    count_next  = count;
    do_write    = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      store_next[i] = store[i];
    end

    if (cmd.is_insert && count == CNT_W'(CAP)) begin
      status_next = olde_pkg::ST_FULL;
    end else if (cmd.needs_elem && count == '0) begin
      status_next = olde_pkg::ST_EMPTY;
    end else if (cmd.op == olde_pkg::OP_DELETE && hit == '0) begin
      status_next = olde_pkg::ST_NOT_FOUND;
    end else begin
      case (cmd.op)
        olde_pkg::OP_PUSH_FRONT,
        olde_pkg::OP_PUSH_BACK,
        olde_pkg::OP_ORDERED: begin
          do_write   = 1'b1;
          count_next = count + 1'b1;
          for (int i = 0; i < CAP; i++) begin
            if (below[i]) begin
              store_next[i] = store[i];
            end else if (at[i]) begin
              store_next[i] = cmd.value;
            end else if (i > 0) begin
              store_next[i] = store[(i > 0) ? i - 1 : 0];
            end
          end
        end
        olde_pkg::OP_POP_FRONT,
        olde_pkg::OP_DELETE: begin
          do_write   = 1'b1;
          count_next = count - 1'b1;
          // A deleted element equals the target, so the target is the data.
          data_next  = (cmd.op == olde_pkg::OP_POP_FRONT) ? store[0] : cmd.value;
          for (int i = 0; i < CAP - 1; i++) begin
            if (!below[i]) begin
              store_next[i] = store[i + 1];
            end
          end
        end
        olde_pkg::OP_READ_FRONT: begin
          data_next = store[0];
        end
        olde_pkg::OP_READ_BACK: begin
          data_next = store[last];
        end
        default: begin
          data_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= olde_pkg::BK_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= apply_done || (out_valid && !rsp.ready);
      if (apply_done) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
      hit <= hit_next;
    end
    if (apply_done) begin
      out_data   <= data_next;
      out_status <= status_next;
      out_count  <= count_next;
    end
    if (apply_done && do_write) begin
      for (int i = 0; i < CAP; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

endmodule

FILE: src/ordered_list_deque_engine.sv
// A word passes through the command queue, the back end's command register
// and the output register before its result is shown.
// The back end handles one word at a time: it compares all cells as it takes
// a word from the queue, then shifts the list before it takes the next word.
// Reset: synchronous; the list, the command queue and the output register
// come up empty. Stored elements are not cleared.
module ordered_list_deque_engine (
  input  logic        clk,
  input  logic        rst,
  olde_req_if.sink    req,
  olde_rsp_if.source  rsp
);

  logic            wr_en;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  olde_pkg::cmd_t  wr_cmd;
  olde_pkg::cmd_t  q_cmd;

  olde_front u_front (
    .req    (req),
    .q_full (q_full),
    .wr_en  (wr_en),
    .wr_cmd (wr_cmd)
  );

  olde_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_cmd   (wr_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  olde_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule
